// ===== src/ravg_pkg.sv =====
// ravg_pkg: shared constants and types for the running statistics block
// holds widths, the run summary record and the divider request/response structs
// no dependencies
package ravg_pkg;

	// largest number of samples accepted in one run
	localparam int MAX_ITEMS = 1024;

	// fixed field widths
	localparam int T_W    = 32;
	localparam int POS_W  = 10;
	localparam int FRAC_W = 13;

	// derived widths
	localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
	localparam int SUM_W  = T_W + $clog2(MAX_ITEMS);
	// sample times nine, signed, with headroom for the offset
	localparam int F_W    = T_W + 5;
	localparam int DIV_W  = (SUM_W > F_W) ? SUM_W : F_W;
	localparam int DSR_W  = (CNT_W > 3) ? CNT_W : 3;
	localparam int DCNT_W = $clog2(DIV_W);

	// queue between front and back, power of two
	localparam int Q_DEPTH = 2;
	localparam int QA_W    = $clog2(Q_DEPTH);

	// fahrenheit conversion constants
	localparam logic signed [F_W-1:0] F_OFFSET  = F_W'(32) <<< FRAC_W;
	localparam logic signed [F_W-1:0] W32_MAX   = {{(F_W-T_W){1'b0}}, 1'b0, {(T_W-1){1'b1}}};
	localparam logic signed [F_W-1:0] W32_MIN   = {{(F_W-T_W){1'b1}}, 1'b1, {(T_W-1){1'b0}}};

	// divide by five: magnitude of nine times a sample, split at bit 16
	// 65536 is 5 * 13107 + 1, so the upper part divides exactly and the
	// lower sum is divided by a reciprocal multiply
	localparam int MAG_W    = T_W + 3;
	localparam int SPLIT_W  = 16;
	localparam int HI_W     = MAG_W - SPLIT_W;
	localparam int N_W      = HI_W + 1;
	localparam int K5_W     = 14;
	localparam int QF_W     = HI_W + K5_W;
	localparam int R5_SHIFT = 22;
	localparam logic [K5_W-1:0] K5      = K5_W'(13107);
	localparam logic [N_W-1:0]  R5_MULT = N_W'(838861);

	// summary of one finished run
	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [CNT_W-1:0]        count;
		logic signed [T_W-1:0]   min_v;
		logic signed [T_W-1:0]   max_v;
		logic [POS_W-1:0]        min_pos;
		logic [POS_W-1:0]        max_pos;
		logic                    overrun;
	} run_t;

	// divider request and response
	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== src/running_avg_max_min_q13.sv =====
// running_avg_max_min_q13: top level of the streaming min / max / mean block
// instantiates ravg_front, ravg_fifo, ravg_div and ravg_back; uses ravg_pkg
//
// Input channel: one signed Q13 Celsius sample per item (temperature), with
// last marking the final sample of a run. Samples are taken one per cycle
// while the run summary queue has room; in_stall is high only when it is full.
// Samples beyond MAX_ITEMS in a run are dropped and reported as too_long.
// Output channel: one result item per run, carrying the truncated mean, the
// min and max in Celsius and in saturated Fahrenheit, and the positions of
// the first min and max.
// Result path: the result rises on out_valid after the last sample is taken
// and its run passes through the queue, the one-bit-per-cycle divider for the
// mean, the register that takes the quotient and the output register. Both
// Fahrenheit conversions run alongside in a four-stage reciprocal multiply
// pipeline. Throughput: one sample per cycle inside a run while the queue has
// room; a finished run holds the back end until its result is taken into the
// output register, and up to two finished runs wait in the queue.
// Reset clears the running statistics, the queue and the output register.
// When the receiver stalls, the result holds in the output register and the
// back end finishes the next run behind it; samples keep flowing until the
// queue fills.
module running_avg_max_min_q13 (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [ravg_pkg::T_W-1:0] temperature,
	input  logic                            last,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [ravg_pkg::T_W-1:0] mean_c,
	output logic signed [ravg_pkg::T_W-1:0] min_c,
	output logic signed [ravg_pkg::T_W-1:0] max_c,
	output logic signed [ravg_pkg::T_W-1:0] min_f,
	output logic signed [ravg_pkg::T_W-1:0] max_f,
	output logic [ravg_pkg::POS_W-1:0]      min_position,
	output logic [ravg_pkg::POS_W-1:0]      max_position,
	output logic                            too_long
);
	import ravg_pkg::*;

	logic     q_full;
	logic     q_push;
	run_t     q_push_run;
	logic     q_pop;
	logic     q_valid;
	run_t     q_head;
	div_req_t div_req;
	div_rsp_t div_rsp;

	// sample intake and running statistics
	ravg_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.temperature (temperature),
		.last        (last),
		.q_full      (q_full),
		.push        (q_push),
		.push_run    (q_push_run)
	);

	// finished runs waiting for the back end
	ravg_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_run (q_push_run),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (q_head)
	);

	// serial divider for the mean
	ravg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// mean and conversion sequencer with output register
	ravg_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.div_req      (div_req),
		.div_rsp      (div_rsp),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.mean_c       (mean_c),
		.min_c        (min_c),
		.max_c        (max_c),
		.min_f        (min_f),
		.max_f        (max_f),
		.min_position (min_position),
		.max_position (max_position),
		.too_long     (too_long)
	);

endmodule

// ===== src/ravg_front.sv =====
// ravg_front: accepts samples and keeps running sum, extremes, positions and count
// pushes one run summary into the queue on the last sample
// depends on ravg_pkg
module ravg_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [ravg_pkg::T_W-1:0] temperature,
	input  logic                          last,
	input  logic                          q_full,
	output logic                          push,
	output ravg_pkg::run_t                push_run
);
	import ravg_pkg::*;

	logic signed [SUM_W-1:0] sum_q;
	logic signed [T_W-1:0]   min_q;
	logic signed [T_W-1:0]   max_q;
	logic [POS_W-1:0]        min_pos_q;
	logic [POS_W-1:0]        max_pos_q;
	logic [CNT_W-1:0]        count_q;
	logic                    overrun_q;
	logic                    accept;
	run_t                    nxt;

	// handshake
	assign in_stall = q_full;
	assign accept   = in_valid & ~q_full;
	assign push     = accept & last;
	assign push_run = nxt;

	// statistics update for the incoming item
	always_comb begin
		nxt.sum     = sum_q;
		nxt.count   = count_q;
		nxt.min_v   = min_q;
		nxt.max_v   = max_q;
		nxt.min_pos = min_pos_q;
		nxt.max_pos = max_pos_q;
		nxt.overrun = overrun_q;
		if (count_q == '0) begin
			nxt.sum     = SUM_W'(temperature);
			nxt.min_v   = temperature;
			nxt.max_v   = temperature;
			nxt.min_pos = '0;
			nxt.max_pos = '0;
			nxt.count   = CNT_W'(1);
		end else if (count_q < CNT_W'(MAX_ITEMS)) begin
			nxt.sum = sum_q + SUM_W'(temperature);
			if (temperature > max_q) begin
				nxt.max_v   = temperature;
				nxt.max_pos = POS_W'(count_q);
			end
			if (temperature < min_q) begin
				nxt.min_v   = temperature;
				nxt.min_pos = POS_W'(count_q);
			end
			nxt.count = count_q + 1'b1;
		end else begin
			nxt.overrun = 1'b1;
		end
	end

	// running state, cleared after the last item of a run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			min_q     <= '0;
			max_q     <= '0;
			min_pos_q <= '0;
			max_pos_q <= '0;
			count_q   <= '0;
			overrun_q <= 1'b0;
		end else if (accept) begin
			if (last) begin
				sum_q     <= '0;
				min_q     <= '0;
				max_q     <= '0;
				min_pos_q <= '0;
				max_pos_q <= '0;
				count_q   <= '0;
				overrun_q <= 1'b0;
			end else begin
				sum_q     <= nxt.sum;
				min_q     <= nxt.min_v;
				max_q     <= nxt.max_v;
				min_pos_q <= nxt.min_pos;
				max_pos_q <= nxt.max_pos;
				count_q   <= nxt.count;
				overrun_q <= nxt.overrun;
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ITEMS))
		else $error("sample count above limit");

	a_push_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_run.count != '0))
		else $error("run pushed with zero count");

	a_overrun_full: assert property (@(posedge clk) disable iff (!arst_n)
		overrun_q |-> (count_q == CNT_W'(MAX_ITEMS)))
		else $error("overrun flagged before run was full");

endmodule

// ===== src/ravg_fifo.sv =====
// ravg_fifo: short queue of run summaries between front and back
// depends on ravg_pkg
module ravg_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ravg_pkg::run_t push_run,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output ravg_pkg::run_t head
);
	import ravg_pkg::*;

	run_t            mem_q [Q_DEPTH];
	logic [QA_W-1:0] wr_ptr_q;
	logic [QA_W-1:0] rd_ptr_q;
	logic [QA_W:0]   level_q;

	assign full  = (level_q == (QA_W+1)'(Q_DEPTH));
	assign valid = (level_q != '0);
	assign head  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_run;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid)
		else $error("pop from empty queue");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= (QA_W+1)'(Q_DEPTH))
		else $error("queue level out of range");

endmodule

// ===== src/ravg_div.sv =====
// ravg_div: unsigned restoring divider, one quotient bit per cycle
// depends on ravg_pkg
module ravg_div (
	input  logic               clk,
	input  logic               arst_n,
	input  ravg_pkg::div_req_t req,
	output ravg_pkg::div_rsp_t rsp
);
	import ravg_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DSR_W-1:0]  rem_q;
	logic [DSR_W-1:0]  dsr_q;
	logic [DSR_W:0]    trial;
	logic [DSR_W:0]    diff;
	logic              ge;

	// one trial subtraction
	always_comb begin
		trial = {rem_q, quo_q[DIV_W-1]};
		diff  = trial - {1'b0, dsr_q};
		ge    = (trial >= {1'b0, dsr_q});
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(DIV_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("done without preceding division");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (dsr_q != '0))
		else $error("division by zero");

endmodule

// ===== src/ravg_back.sv =====
// ravg_back: takes run summaries from the queue, computes the mean on the serial
// divider and the fahrenheit values in a multiply pipeline, holds the result item
// depends on ravg_pkg
module ravg_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_valid,
	input  ravg_pkg::run_t                  q_head,
	output logic                            q_pop,
	output ravg_pkg::div_req_t              div_req,
	input  ravg_pkg::div_rsp_t              div_rsp,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [ravg_pkg::T_W-1:0] mean_c,
	output logic signed [ravg_pkg::T_W-1:0] min_c,
	output logic signed [ravg_pkg::T_W-1:0] max_c,
	output logic signed [ravg_pkg::T_W-1:0] min_f,
	output logic signed [ravg_pkg::T_W-1:0] max_f,
	output logic [ravg_pkg::POS_W-1:0]      min_position,
	output logic [ravg_pkg::POS_W-1:0]      max_position,
	output logic                            too_long
);
	import ravg_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_MEAN, S_EMIT} state_t;

	state_t                  state_q;
	run_t                    run_q;
	logic signed [T_W-1:0]   mean_q;
	logic [MAG_W-1:0]        min_mag_s1;
	logic [MAG_W-1:0]        max_mag_s1;
	logic                    min_neg_s1;
	logic                    max_neg_s1;
	logic [N_W-1:0]          min_n_s2;
	logic [N_W-1:0]          max_n_s2;
	logic [QF_W-1:0]         min_hi_s2;
	logic [QF_W-1:0]         max_hi_s2;
	logic                    min_neg_s2;
	logic                    max_neg_s2;
	logic [QF_W-1:0]         min_quo_s3;
	logic [QF_W-1:0]         max_quo_s3;
	logic                    min_neg_s3;
	logic                    max_neg_s3;
	logic signed [T_W-1:0]   fmin_q;
	logic signed [T_W-1:0]   fmax_q;
	logic                    out_valid_q;
	logic signed [T_W-1:0]   mean_c_q;
	logic signed [T_W-1:0]   min_c_q;
	logic signed [T_W-1:0]   max_c_q;
	logic signed [T_W-1:0]   min_f_q;
	logic signed [T_W-1:0]   max_f_q;
	logic [POS_W-1:0]        min_pos_q;
	logic [POS_W-1:0]        max_pos_q;
	logic                    too_long_q;
	logic [SUM_W-1:0]        head_mag;
	logic [T_W-1:0]          quo_lo;
	logic                    emit;

	// magnitude of nine times a sample
	function automatic logic [MAG_W-1:0] times9_mag(input logic signed [T_W-1:0] c);
		logic signed [F_W-1:0] p;
		p = (F_W'(c) <<< 3) + F_W'(c);
		return p[F_W-1] ? MAG_W'(-p) : MAG_W'(p);
	endfunction

	// upper part plus lower part, still to be divided by five
	function automatic logic [N_W-1:0] fold_low(input logic [MAG_W-1:0] m);
		return N_W'(m[MAG_W-1:SPLIT_W]) + N_W'(m[SPLIT_W-1:0]);
	endfunction

	// exact quotient of the upper part
	function automatic logic [QF_W-1:0] upper_quo(input logic [MAG_W-1:0] m);
		logic [HI_W-1:0] a;
		logic [QF_W-1:0] p;
		a = m[MAG_W-1:SPLIT_W];
		p = a * K5;
		return p;
	endfunction

	// reciprocal multiply, exact for operands below 2**R5_SHIFT
	function automatic logic [QF_W-1:0] div5_join(input logic [N_W-1:0] n,
		input logic [QF_W-1:0] hi);
		logic [2*N_W-1:0] p;
		p = n * R5_MULT;
		return hi + QF_W'(p[2*N_W-1:R5_SHIFT]);
	endfunction

	// signed quotient plus offset, saturated to 32 bits
	function automatic logic signed [T_W-1:0] fahr_sat(input logic neg,
		input logic [QF_W-1:0] q);
		logic signed [F_W-1:0] mag;
		logic signed [F_W-1:0] f;
		mag = {{(F_W-QF_W){1'b0}}, q};
		f   = (neg ? -mag : mag) + F_OFFSET;
		if (f > W32_MAX) begin
			f = W32_MAX;
		end else if (f < W32_MIN) begin
			f = W32_MIN;
		end
		return f[T_W-1:0];
	endfunction

	// operand magnitude for the mean and quotient low word
	always_comb begin
		head_mag = q_head.sum[SUM_W-1] ? SUM_W'(-q_head.sum) : SUM_W'(q_head.sum);
		quo_lo   = div_rsp.quotient[T_W-1:0];
	end

	// divider sequencing
	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign emit  = (state_q == S_EMIT) && (!out_valid_q || !out_stall);

	always_comb begin
		div_req.start    = q_pop;
		div_req.dividend = DIV_W'(head_mag);
		div_req.divisor  = DSR_W'(q_head.count);
	end

	// fahrenheit pipeline, follows run_q through the s1, s2 and s3 stages and
	// fmin_q/fmax_q, settling well inside the divider time for the mean
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_mag_s1 <= '0;
			max_mag_s1 <= '0;
			min_neg_s1 <= 1'b0;
			max_neg_s1 <= 1'b0;
			min_n_s2   <= '0;
			max_n_s2   <= '0;
			min_hi_s2  <= '0;
			max_hi_s2  <= '0;
			min_neg_s2 <= 1'b0;
			max_neg_s2 <= 1'b0;
			min_quo_s3 <= '0;
			max_quo_s3 <= '0;
			min_neg_s3 <= 1'b0;
			max_neg_s3 <= 1'b0;
			fmin_q     <= '0;
			fmax_q     <= '0;
		end else begin
			min_mag_s1 <= times9_mag(run_q.min_v);
			max_mag_s1 <= times9_mag(run_q.max_v);
			min_neg_s1 <= run_q.min_v[T_W-1];
			max_neg_s1 <= run_q.max_v[T_W-1];
			min_n_s2   <= fold_low(min_mag_s1);
			max_n_s2   <= fold_low(max_mag_s1);
			min_hi_s2  <= upper_quo(min_mag_s1);
			max_hi_s2  <= upper_quo(max_mag_s1);
			min_neg_s2 <= min_neg_s1;
			max_neg_s2 <= max_neg_s1;
			min_quo_s3 <= div5_join(min_n_s2, min_hi_s2);
			max_quo_s3 <= div5_join(max_n_s2, max_hi_s2);
			min_neg_s3 <= min_neg_s2;
			max_neg_s3 <= max_neg_s2;
			fmin_q     <= fahr_sat(min_neg_s3, min_quo_s3);
			fmax_q     <= fahr_sat(max_neg_s3, max_quo_s3);
		end
	end

	// state, mean and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			run_q       <= '0;
			mean_q      <= '0;
			out_valid_q <= 1'b0;
			mean_c_q    <= '0;
			min_c_q     <= '0;
			max_c_q     <= '0;
			min_f_q     <= '0;
			max_f_q     <= '0;
			min_pos_q   <= '0;
			max_pos_q   <= '0;
			too_long_q  <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !emit) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						run_q   <= q_head;
						state_q <= S_MEAN;
					end
				end
				S_MEAN: begin
					if (div_rsp.done) begin
						mean_q  <= run_q.sum[SUM_W-1] ? -quo_lo : quo_lo;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit) begin
						out_valid_q <= 1'b1;
						mean_c_q    <= mean_q;
						min_c_q     <= run_q.min_v;
						max_c_q     <= run_q.max_v;
						min_f_q     <= fmin_q;
						max_f_q     <= fmax_q;
						min_pos_q   <= run_q.min_pos;
						max_pos_q   <= run_q.max_pos;
						too_long_q  <= run_q.overrun;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign mean_c       = mean_c_q;
	assign min_c        = min_c_q;
	assign max_c        = max_c_q;
	assign min_f        = min_f_q;
	assign max_f        = max_f_q;
	assign min_position = min_pos_q;
	assign max_position = max_pos_q;
	assign too_long     = too_long_q;

	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider request while busy");

	a_div_active: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MEAN) |-> (div_rsp.busy || div_rsp.done))
		else $error("waiting on idle divider");

	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_MEAN))
		else $error("divider result with no consumer");

endmodule
